// ----- hdl/hbwd_pkg.sv -----
`default_nettype none

package hbwd_pkg;

    // Block dimensions.
    localparam int CHANNELS     = 8;
    localparam int BEAT_WIDTH   = 8;
    localparam int RESULT_CAP   = 8;
    localparam int CH_W         = 3;
    localparam int IDX_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W        = $clog2(RESULT_CAP + 1);
    localparam int MISS_W       = 5;
    localparam int LIMIT_W      = 4;
    localparam int CFG_W        = 32;
    localparam int TDATA_W      = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [CFG_W-1:0] LIMITS_RESET = 32'h5555_5555;

    // Item kinds carried on the input tuser bit.
    typedef enum logic {
        OP_BEAT = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // One classified input item as held in the queue.
    typedef struct packed {
        op_t             op;
        logic [CH_W-1:0] channel;
    } item_t;

    // Head of the queue as seen by the execution side.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // Execution sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } exec_state_t;

    // Tolerated miss count of one channel; channels without limit bits get zero.
    function automatic logic [LIMIT_W-1:0] limit_of(input logic [CFG_W-1:0] limits,
                                                    input logic [IDX_W-1:0] ch);
        logic [LIMIT_W-1:0] lim;
        lim = '0;
        if (int'(ch) * LIMIT_W < CFG_W) begin
            lim = limits[int'(ch) * LIMIT_W +: LIMIT_W];
        end
        return lim;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/multi_channel_heartbeat_watchdog_top.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata[2:0] channel, s_tuser[0] operation
// m_        out        m_tvalid/m_tready  m_tdata[2:0] restart_channel, m_tlast last
// cfg_      in         cfg_wr_en          cfg_wr_data miss_limits (4 bits per channel)
//
// A heartbeat item is handled in the idle state of the execution sequencer.
// A check tick is dequeued, then each channel is scanned in turn through the single read port
// of the channel state, and then the final result is flushed.
// A two-entry input queue keeps accepting items, until it is full, while the sequencer works or stalls.
// The scan stalls only when a restart must go out while the output register is full.
// Reset is synchronous on aresetn low and clears all counters and the limits to 0x55555555.
`default_nettype none

module multi_channel_heartbeat_watchdog_top
    import hbwd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [TDATA_W-1:0]  s_tdata,   // [2:0] channel, [7:3] zero fill
    input  wire logic [0:0]          s_tuser,   // [0] operation
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,   // [2:0] restart_channel, [7:3] zero fill
    output logic                     m_tlast
);

    queue_head_t      head;
    logic             pop;
    logic [CH_W-1:0]  out_channel;

    // Front: accept and classify items into the queue.
    hbwd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_channel   (s_tdata[CH_W-1:0]),
        .s_operation (s_tuser[0]),
        .pop         (pop),
        .head        (head)
    );

    // Back: execute heartbeats and check scans.
    hbwd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (out_channel),
        .out_last    (m_tlast)
    );

    assign m_tdata = {{(TDATA_W - CH_W){1'b0}}, out_channel};

endmodule

`default_nettype wire

// ----- hdl/hbwd_front.sv -----
`default_nettype none

module hbwd_front
    import hbwd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_channel,
    input  wire logic        s_operation,
    input  wire logic        pop,
    output queue_head_t      head
);

    item_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    item_t               in_item;
    logic                push;
    logic                pop_ok;

    // Classify the incoming item by its kind bit.
    always_comb begin
        in_item.op      = s_operation ? OP_TICK : OP_BEAT;
        in_item.channel = s_channel;
    end

    assign s_tready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign pop_ok     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

    // Queue pointers and fill level.
    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop_ok) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hbwd_back.sv -----
`default_nettype none

module hbwd_back
    import hbwd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire queue_head_t       head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CH_W-1:0]        out_channel,
    output logic                   out_last
);

    exec_state_t            state_reg, state_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]       pend_ch_reg, pend_ch_next;
    logic [CFG_W-1:0]       limits_reg, limits_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CH_W-1:0]        out_ch_reg, out_ch_next;
    logic                   out_last_reg, out_last_next;

    logic [BEAT_WIDTH-1:0]  beat_reg [CHANNELS];
    logic [BEAT_WIDTH-1:0]  seen_reg [CHANNELS];
    logic [MISS_W-1:0]      miss_reg [CHANNELS];

    logic [IDX_W-1:0]       rd_idx;
    logic [BEAT_WIDTH-1:0]  beat_rd;
    logic [BEAT_WIDTH-1:0]  seen_rd;
    logic [MISS_W-1:0]      miss_inc;
    logic                   differ;
    logic                   restart;
    logic                   report;
    logic                   out_free;
    logic                   scan_go;
    logic                   last_idx;
    logic                   in_range;
    logic                   beat_we;
    logic                   tick_start;
    logic                   scan_step;
    logic                   emit_mid;
    logic                   emit_final;

    // Channel state is read at one place: the heartbeat's channel or the scan index.
    assign rd_idx   = (state_reg == ST_IDLE) ? head.item.channel[IDX_W-1:0] : scan_idx_reg;
    assign beat_rd  = beat_reg[rd_idx];
    assign seen_rd  = seen_reg[rd_idx];
    assign miss_inc = miss_reg[rd_idx] + 1'b1;
    assign differ   = (beat_rd != seen_rd);
    assign restart  = !differ && (miss_inc > MISS_W'(limit_of(limits_reg, rd_idx)));
    assign report   = restart && (n_reg < CNT_W'(RESULT_CAP));
    assign in_range = (int'(head.item.channel) < CHANNELS);

    // A restart is held back one find so that the final one can carry last.
    assign out_free = !out_valid_reg || out_ready;
    assign scan_go  = !(report && pend_valid_reg) || out_free;
    assign last_idx = (scan_idx_reg == IDX_W'(CHANNELS - 1));

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid && head.item.op == OP_TICK) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_go && last_idx) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        pop        = 1'b0;
        scan_step  = 1'b0;
        emit_final = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                pop = head.valid;
            end
            ST_SCAN: begin
                scan_step = scan_go;
            end
            ST_FLUSH: begin
                emit_final = pend_valid_reg && out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign beat_we    = pop && (head.item.op == OP_BEAT) && in_range;
    assign tick_start = pop && (head.item.op == OP_TICK);
    assign emit_mid   = scan_step && report && pend_valid_reg;

    // Scan bookkeeping, pending restart and output register.
    always_comb begin
        scan_idx_next   = scan_idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        limits_next     = cfg_wr_en ? cfg_wr_data : limits_reg;
        out_valid_next  = out_valid_reg;
        out_ch_next     = out_ch_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (tick_start) begin
            scan_idx_next   = '0;
            n_next          = '0;
            pend_valid_next = 1'b0;
        end
        if (scan_step) begin
            scan_idx_next = scan_idx_reg + 1'b1;
            if (report) begin
                pend_valid_next = 1'b1;
                pend_ch_next    = scan_idx_reg;
                n_next          = n_reg + 1'b1;
            end
        end
        if (emit_mid) begin
            out_valid_next = 1'b1;
            out_ch_next    = CH_W'(pend_ch_reg);
            out_last_next  = 1'b0;
        end
        if (emit_final) begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_ch_next     = CH_W'(pend_ch_reg);
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            limits_reg     <= LIMITS_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            limits_reg     <= limits_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_ch_reg  <= pend_ch_next;
        out_ch_reg   <= out_ch_next;
        out_last_reg <= out_last_next;
    end

    // Per-channel counters: heartbeat bumps the beat count, a scan step checks one channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CHANNELS; k++) begin
                beat_reg[k] <= '0;
                seen_reg[k] <= '0;
                miss_reg[k] <= '0;
            end
        end else begin
            if (beat_we) begin
                beat_reg[rd_idx] <= beat_rd + 1'b1;
            end
            if (scan_step) begin
                if (differ) begin
                    seen_reg[rd_idx] <= beat_rd;
                end else begin
                    miss_reg[rd_idx] <= restart ? '0 : miss_inc;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/hbwd_checker.sv -----
`default_nettype none

module hbwd_checker
    import hbwd_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [TDATA_W-1:0]  m_tdata,
    input wire logic                m_tlast
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Fill bits above the channel number stay zero.
    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_W-1:CH_W] == '0))
        else $error("result fill bits not zero");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Reset empties the input queue, so the block can take an item.
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind multi_channel_heartbeat_watchdog_top hbwd_checker u_hbwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
